// ===== sv/tprs_pkg.sv =====
// ----------------------------------------------------------------------------
// tprs_pkg - shared types, constants and arithmetic for the torus point path
// Fixed-point format, sine polynomial coefficients, pipeline depths and the
// Q30 multiply used by the sine lanes and the rotation stages.
// ----------------------------------------------------------------------------
`default_nettype none

package tprs_pkg;

   // Q30 working format, wide enough for every intermediate term
   localparam int Q_W = 36;
   typedef logic signed [Q_W-1:0] q_type;

   localparam q_type Q_ONE = 36'sd1073741824;
   localparam q_type Q_TWO = 36'sd2147483648;
   localparam q_type Q_FIVE = 36'sd5368709120;

   // Default angle resolution
   localparam int ANGLE_BITS_DEF = 16;

   // Taylor terms of sin(pi/2*u) in Q30
   localparam q_type COEF_A1 = 36'sd1686629713;
   localparam q_type COEF_A3 = 36'sd693598668;
   localparam q_type COEF_A5 = 36'sd85569306;
   localparam q_type COEF_A7 = 36'sd5026995;
   localparam q_type COEF_A9 = 36'sd172272;

   // Constant added after each Horner multiply, innermost first
   localparam int HORNER_STEPS = 4;
   localparam q_type HORNER_ADD [HORNER_STEPS] = '{-COEF_A7, COEF_A5, -COEF_A3, COEF_A1};

   // Depth divider: 16 quotient bits, initial remainder is (5 << 44) >> 16
   localparam int DIV_STAGES = 16;
   localparam int DEN_W = 34;
   localparam logic [DEN_W-1:0] DEPTH_REM0 = 34'd1342177280;

   // Pipeline layout
   localparam int SIN_STAGES = 7;
   localparam int ROT_STAGES = 3;
   localparam int PIPE_DEPTH = SIN_STAGES + ROT_STAGES + 1 + DIV_STAGES;

   // Result fields that ride alongside the divider
   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [3:0]         shade_level;
   } side_type;

   // Q30 multiply, truncated toward zero; b must stay within +-2^30 + margin
   function automatic q_type qmul(input q_type a, input q_type b);
      logic [32:0] mag_a;
      logic [30:0] mag_b;
      logic [63:0] prod;
      q_type       mag_r;
      mag_a = a[Q_W-1] ? 33'(-a) : 33'(a);
      mag_b = b[Q_W-1] ? 31'(-b) : 31'(b);
      prod = 64'(mag_a) * 64'(mag_b);
      mag_r = q_type'({2'b00, prod[63:30]});
      return (a[Q_W-1] != b[Q_W-1]) ? -mag_r : mag_r;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tprs_if.sv =====
// ----------------------------------------------------------------------------
// tprs_if - request and response channels of the torus point block
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface tprs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] tube_angle;
   logic [15:0] sweep_angle;
   logic [15:0] tilt_angle;
   logic [15:0] spin_angle;

   modport source (output valid, output tube_angle, output sweep_angle,
                   output tilt_angle, output spin_angle, input ready);
   modport sink (input valid, input tube_angle, input sweep_angle,
                 input tilt_angle, input spin_angle, output ready);
endinterface

interface tprs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] screen_x;
   logic signed [15:0] screen_y;
   logic [15:0]        depth_term;
   logic [3:0]         shade_level;

   modport source (output valid, output screen_x, output screen_y,
                   output depth_term, output shade_level, input ready);
   modport sink (input valid, input screen_x, input screen_y,
                 input depth_term, input shade_level, output ready);
endinterface

`default_nettype wire

// ===== sv/tprs_sine.sv =====
// ----------------------------------------------------------------------------
// tprs_sine - pipelined Q30 sine of a 16-bit phase
// Quarter-wave fold, odd polynomial by Horner, one multiply per stage,
// clamp to [0, 1] and sign by half wave. Seven register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tprs_sine (
   input  wire logic           clock,
   input  wire logic           advance,
   input  wire logic [15:0]    phase,
   output tprs_pkg::q_type     sine
);

   logic [1:0]      quad;
   logic [14:0]     r_mag;
   tprs_pkg::q_type u_in;

   logic            neg_ff [6];
   tprs_pkg::q_type u_ff [6];
   tprs_pkg::q_type u2_ff [1:4];
   tprs_pkg::q_type acc_ff [2:5];
   tprs_pkg::q_type acc_in [2:5];
   tprs_pkg::q_type u2_in;
   tprs_pkg::q_type sin_raw;
   tprs_pkg::q_type sin_in;
   tprs_pkg::q_type sin_ff;

   // Fold the phase into the first quarter wave
   always_comb begin
      quad = phase[15:14];
      r_mag = {1'b0, phase[13:0]};
      if (quad[0]) begin
         r_mag = 15'd16384 - r_mag;
      end
      u_in = tprs_pkg::q_type'({5'b00000, r_mag, 16'h0000});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff[0] <= quad[1];
         u_ff[0] <= u_in;
      end
   end

   // Square of the reduced argument
   assign u2_in = tprs_pkg::qmul(u_ff[0], u_ff[0]);

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff[1] <= neg_ff[0];
         u_ff[1] <= u_ff[0];
         u2_ff[1] <= u2_in;
      end
   end

   // Horner steps, one coefficient per stage
   for (genvar k = 2; k <= 5; k++) begin : g_horner
      if (k == 2) begin : g_seed
         assign acc_in[k] = tprs_pkg::qmul(tprs_pkg::COEF_A9, u2_ff[k-1])
                            + tprs_pkg::HORNER_ADD[k-2];
      end else begin : g_step
         assign acc_in[k] = tprs_pkg::qmul(acc_ff[k-1], u2_ff[k-1])
                            + tprs_pkg::HORNER_ADD[k-2];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            neg_ff[k] <= neg_ff[k-1];
            u_ff[k] <= u_ff[k-1];
            acc_ff[k] <= acc_in[k];
         end
      end

      if (k < 5) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               u2_ff[k] <= u2_ff[k-1];
            end
         end
      end
   end

   // Last multiply, clamp and sign
   always_comb begin
      sin_raw = tprs_pkg::qmul(acc_ff[5], u_ff[5]);
      if (sin_raw < 0) begin
         sin_raw = '0;
      end
      if (sin_raw > tprs_pkg::Q_ONE) begin
         sin_raw = tprs_pkg::Q_ONE;
      end
      sin_in = neg_ff[5] ? -sin_raw : sin_raw;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sin_ff <= sin_in;
      end
   end

   assign sine = sin_ff;

endmodule

`default_nettype wire

// ===== sv/tprs_divide.sv =====
// ----------------------------------------------------------------------------
// tprs_divide - pipelined depth divider, (5 << 44) / den saturated to 16 bits
// One setup stage, then one restoring step per stage for 16 quotient bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tprs_divide (
   input  wire logic            clock,
   input  wire logic            advance,
   input  wire tprs_pkg::q_type den,
   output logic [15:0]          depth_term
);

   localparam int NS = tprs_pkg::DIV_STAGES;
   localparam int DW = tprs_pkg::DEN_W;

   logic          sat_ff [NS+1];
   logic [DW-1:0] den_ff [NS+1];
   logic [DW-1:0] rem_ff [NS+1];
   logic [15:0]   quo_ff [NS+1];
   logic          sat_in;

   // Quotient overflows 16 bits when den is at most 5 * 2^28, also den < 1
   assign sat_in = (den <= tprs_pkg::q_type'(tprs_pkg::DEPTH_REM0));

   always_ff @(posedge clock) begin
      if (advance) begin
         sat_ff[0] <= sat_in;
         den_ff[0] <= den[DW-1:0];
         rem_ff[0] <= tprs_pkg::DEPTH_REM0;
         quo_ff[0] <= '0;
      end
   end

   // One quotient bit per stage
   for (genvar j = 1; j <= NS; j++) begin : g_step
      logic [DW:0]   rem_sh;
      logic          ge;
      logic [DW-1:0] rem_in;

      always_comb begin
         rem_sh = {rem_ff[j-1], 1'b0};
         ge = (rem_sh >= {1'b0, den_ff[j-1]});
         rem_in = ge ? DW'(rem_sh - {1'b0, den_ff[j-1]}) : rem_sh[DW-1:0];
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            sat_ff[j] <= sat_ff[j-1];
            den_ff[j] <= den_ff[j-1];
            rem_ff[j] <= rem_in;
            quo_ff[j] <= {quo_ff[j-1][14:0], ge};
         end
      end
   end

   assign depth_term = sat_ff[NS] ? 16'hFFFF : quo_ff[NS];

endmodule

`default_nettype wire

// ===== sv/torus_point_rotate_shade.sv =====
// ----------------------------------------------------------------------------
// torus_point_rotate_shade - screen position, depth and shade of a torus point
// Each request names a surface point (tube and sweep angle) and the frame
// rotation (tilt and spin angle); the response gives 3*x and 3*y, the depth
// term 5/(depth+5) and a 0..11 shade level.
//
// Channels: req_ch (sink) and rsp_ch (source), valid/ready, one response per
// request, in request order.
// Path from request to response: 7 stages of sine polynomial, 3 stages
// of rotation products, 1 divider setup stage and 16 divider stages, one
// bit each. Throughput: one request per cycle while rsp_ch does not stall;
// the pipeline is fully registered, one multiply or wide compare per stage.
// Stall: while a response waits on rsp_ch, the whole pipeline holds and
// req_ch.ready is low; nothing is dropped or repeated. Empty stages do not
// block: ready stays high whenever the output register is free or taken.
// Reset: synchronous, clears all stage valid bits; no response is pending.
// ----------------------------------------------------------------------------
`default_nettype none

module torus_point_rotate_shade #(
   parameter int ANGLE_BITS = tprs_pkg::ANGLE_BITS_DEF
) (
   input wire logic       clock,
   input wire logic       reset,
   tprs_req_if.sink       req_ch,
   tprs_rsp_if.source     rsp_ch
);

   localparam int L = tprs_pkg::PIPE_DEPTH;
   localparam int DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
   localparam logic [15:0] ANGLE_MASK = 16'(16'hFFFF << DROP);
   localparam logic [15:0] QUARTER = 16'h4000;

   typedef tprs_pkg::q_type q_type;

   logic           advance;
   logic [L-1:0]   vld_ff;
   logic [L-1:0]   vld_in;

   // Hold every stage while the output register is full and not taken
   assign advance = !vld_ff[L-1] || rsp_ch.ready;
   assign req_ch.ready = advance;
   assign vld_in = {vld_ff[L-2:0], req_ch.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   // Quantized phases, cosine as sine a quarter turn ahead
   logic [15:0] tube_p, sweep_p, tilt_p, spin_p;
   assign tube_p = req_ch.tube_angle & ANGLE_MASK;
   assign sweep_p = req_ch.sweep_angle & ANGLE_MASK;
   assign tilt_p = req_ch.tilt_angle & ANGLE_MASK;
   assign spin_p = req_ch.spin_angle & ANGLE_MASK;

   q_type c, l, d, f, e, g, m, n;

   tprs_sine u_sin_sweep (.clock, .advance, .phase(sweep_p), .sine(c));
   tprs_sine u_cos_sweep (.clock, .advance, .phase(16'(sweep_p + QUARTER)), .sine(l));
   tprs_sine u_cos_tube (.clock, .advance, .phase(16'(tube_p + QUARTER)), .sine(d));
   tprs_sine u_sin_tube (.clock, .advance, .phase(tube_p), .sine(f));
   tprs_sine u_sin_tilt (.clock, .advance, .phase(tilt_p), .sine(e));
   tprs_sine u_cos_tilt (.clock, .advance, .phase(16'(tilt_p + QUARTER)), .sine(g));
   tprs_sine u_cos_spin (.clock, .advance, .phase(16'(spin_p + QUARTER)), .sine(m));
   tprs_sine u_sin_spin (.clock, .advance, .phase(spin_p), .sine(n));

   // First products: circle point and sweep terms
   q_type h;
   q_type r1_ch_ff, r1_fg_ff, r1_fe_ff, r1_lh_ff, r1_cd_ff, r1_ld_ff;
   q_type r1_e_ff, r1_g_ff, r1_m_ff, r1_n_ff;

   assign h = d + tprs_pkg::Q_TWO;

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ch_ff <= tprs_pkg::qmul(h, c);
         r1_fg_ff <= tprs_pkg::qmul(f, g);
         r1_fe_ff <= tprs_pkg::qmul(f, e);
         r1_lh_ff <= tprs_pkg::qmul(h, l);
         r1_cd_ff <= tprs_pkg::qmul(c, d);
         r1_ld_ff <= tprs_pkg::qmul(l, d);
         r1_e_ff <= e;
         r1_g_ff <= g;
         r1_m_ff <= m;
         r1_n_ff <= n;
      end
   end

   // Second products: tilt rotation
   q_type r2_che_ff, r2_chg_ff, r2_cdg_ff, r2_cde_ff, r2_ldn_ff;
   q_type r2_fg_ff, r2_fe_ff, r2_lh_ff, r2_m_ff, r2_n_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         r2_che_ff <= tprs_pkg::qmul(r1_ch_ff, r1_e_ff);
         r2_chg_ff <= tprs_pkg::qmul(r1_ch_ff, r1_g_ff);
         r2_cdg_ff <= tprs_pkg::qmul(r1_cd_ff, r1_g_ff);
         r2_cde_ff <= tprs_pkg::qmul(r1_cd_ff, r1_e_ff);
         r2_ldn_ff <= tprs_pkg::qmul(r1_ld_ff, r1_n_ff);
         r2_fg_ff <= r1_fg_ff;
         r2_fe_ff <= r1_fe_ff;
         r2_lh_ff <= r1_lh_ff;
         r2_m_ff <= r1_m_ff;
         r2_n_ff <= r1_n_ff;
      end
   end

   // Third products: spin rotation, and the depth denominator
   q_type t_val, a_val;
   q_type r3_tn_ff, r3_tm_ff, r3_lhm_ff, r3_lhn_ff, r3_am_ff;
   q_type r3_den_ff, r3_cde_ff, r3_fg_ff, r3_ldn_ff;

   assign t_val = r2_chg_ff - r2_fe_ff;
   assign a_val = r2_fe_ff - r2_cdg_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         r3_tn_ff <= tprs_pkg::qmul(t_val, r2_n_ff);
         r3_tm_ff <= tprs_pkg::qmul(t_val, r2_m_ff);
         r3_lhm_ff <= tprs_pkg::qmul(r2_lh_ff, r2_m_ff);
         r3_lhn_ff <= tprs_pkg::qmul(r2_lh_ff, r2_n_ff);
         r3_am_ff <= tprs_pkg::qmul(a_val, r2_m_ff);
         r3_den_ff <= r2_che_ff + r2_fg_ff + tprs_pkg::Q_FIVE;
         r3_cde_ff <= r2_cde_ff;
         r3_fg_ff <= r2_fg_ff;
         r3_ldn_ff <= r2_ldn_ff;
      end
   end

   // Scale by 3, divide by 2^19 toward zero, saturate to 16 bits
   function automatic logic signed [15:0] to_screen(input q_type v);
      logic signed [37:0] ext;
      logic signed [37:0] v3;
      logic signed [37:0] sh;
      ext = 38'(v);
      v3 = (ext <<< 1) + ext;
      if (v3 < 0) begin
         v3 = v3 + 38'sd524287;
      end
      sh = v3 >>> 19;
      if (sh > 38'sd32767) begin
         return 16'sh7FFF;
      end else if (sh < -38'sd32768) begin
         return -16'sh8000;
      end
      return sh[15:0];
   endfunction

   // Final sums, screen scaling and shade
   q_type x_val, y_val, lum_val;
   logic [7:0] lum_int;
   tprs_pkg::side_type side_in;

   always_comb begin
      x_val = r3_lhm_ff - r3_tn_ff;
      y_val = r3_lhn_ff + r3_tm_ff;
      lum_val = r3_am_ff - r3_cde_ff - r3_fg_ff - r3_ldn_ff;
      lum_int = lum_val[34:27];
      side_in.screen_x = to_screen(x_val);
      side_in.screen_y = to_screen(y_val);
      if (lum_val[tprs_pkg::Q_W-1]) begin
         side_in.shade_level = 4'd0;
      end else if (lum_int > 8'd11) begin
         side_in.shade_level = 4'd11;
      end else begin
         side_in.shade_level = lum_int[3:0];
      end
   end

   // Carry the screen fields alongside the divider
   tprs_pkg::side_type side_ff [tprs_pkg::DIV_STAGES+1];

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int i = 1; i <= tprs_pkg::DIV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   logic [15:0] depth_val;

   tprs_divide u_divide (
      .clock,
      .advance,
      .den(r3_den_ff),
      .depth_term(depth_val)
   );

   // Response drive
   assign rsp_ch.valid = vld_ff[L-1];
   assign rsp_ch.screen_x = side_ff[tprs_pkg::DIV_STAGES].screen_x;
   assign rsp_ch.screen_y = side_ff[tprs_pkg::DIV_STAGES].screen_y;
   assign rsp_ch.shade_level = side_ff[tprs_pkg::DIV_STAGES].shade_level;
   assign rsp_ch.depth_term = depth_val;

`ifndef SYNTHESIS
   a_stall_holds_valids: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(vld_ff))
      else $error("stage valid bits moved during a stall");

   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> (rsp_ch.shade_level <= 4'd11))
      else $error("shade level out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_ch.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top - testbench of the torus point rotate and shade block
// Drives random and corner-case torus points with random idle bursts on both
// channels, predicts screen position, depth term and shade level in fixed
// point, and checks every response in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int N_RANDOM = 1400;
   localparam int WATCHDOG = 20000;
   localparam int LATENCY = 27;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic [15:0]        depth_term;
      logic [3:0]         shade_level;
   } shade_result_type;

   // Fixed-point model of one torus point
   class point_scoreboard;
      shade_result_type pending_q[$];
      int               error_count = 0;

      static function longint mult_q30(longint a, longint b);
         longint unsigned ma, mb, p;
         ma = (a < 0) ? -a : a;
         mb = (b < 0) ? -b : b;
         p = (ma * mb) >> 30;
         return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
      endfunction

      static function longint sine_q30(logic [15:0] phase);
         logic [1:0] quad;
         longint     r, u, u2, acc, s;
         quad = phase[15:14];
         r = phase[13:0];
         if (quad[0]) r = 16384 - r;
         u = r << 16;
         u2 = mult_q30(u, u);
         acc = 172272;
         acc = -5026995 + mult_q30(acc, u2);
         acc = 85569306 + mult_q30(acc, u2);
         acc = -693598668 + mult_q30(acc, u2);
         acc = 1686629713 + mult_q30(acc, u2);
         s = mult_q30(acc, u);
         if (s < 0) s = 0;
         if (s > (64'sd1 << 30)) s = 64'sd1 << 30;
         return quad[1] ? -s : s;
      endfunction

      static function logic [15:0] screen_coord(longint v);
         longint s;
         s = (3 * v) / (64'sd1 << 19);
         if (s > 32767) s = 32767;
         if (s < -32768) s = -32768;
         return s[15:0];
      endfunction

      // Note one accepted request and queue its expected response
      function void note_request(logic [15:0] tube, logic [15:0] sweep,
                                 logic [15:0] tilt, logic [15:0] spin);
         longint        c, l, d, f, e, g, m, n, h, den, t, lh, x, y, cd, lum, shd;
         longint unsigned dep;
         shade_result_type res;
         c = sine_q30(sweep);
         l = sine_q30(sweep + 16'd16384);
         d = sine_q30(tube + 16'd16384);
         f = sine_q30(tube);
         e = sine_q30(tilt);
         g = sine_q30(tilt + 16'd16384);
         m = sine_q30(spin + 16'd16384);
         n = sine_q30(spin);
         h = d + (64'sd2 << 30);
         den = mult_q30(mult_q30(c, h), e) + mult_q30(f, g) + (64'sd5 << 30);
         t = mult_q30(mult_q30(c, h), g) - mult_q30(f, e);
         lh = mult_q30(l, h);
         x = mult_q30(lh, m) - mult_q30(t, n);
         y = mult_q30(lh, n) + mult_q30(t, m);
         cd = mult_q30(c, d);
         lum = mult_q30(mult_q30(f, e) - mult_q30(cd, g), m) - mult_q30(cd, e)
               - mult_q30(f, g) - mult_q30(mult_q30(l, d), n);
         shd = (8 * lum) / (64'sd1 << 30);
         if (den < 1) den = 1;
         dep = (64'd5 << 44) / longint'(den);
         if (dep > 65535) dep = 65535;
         if (shd < 0) shd = 0;
         if (shd > 11) shd = 11;
         res.screen_x = screen_coord(x);
         res.screen_y = screen_coord(y);
         res.depth_term = dep[15:0];
         res.shade_level = shd[3:0];
         pending_q.push_back(res);
      endfunction

      // Compare one response with the oldest expectation
      function void check_response(shade_result_type act);
         shade_result_type exp_r;
         if (pending_q.size() == 0) begin
            $error("unexpected response x=%0d y=%0d", act.screen_x, act.screen_y);
            error_count++;
            return;
         end
         exp_r = pending_q.pop_front();
         if (act.screen_x !== exp_r.screen_x) begin
            $error("screen_x: expected %0d, actual %0d", exp_r.screen_x, act.screen_x);
            error_count++;
         end
         if (act.screen_y !== exp_r.screen_y) begin
            $error("screen_y: expected %0d, actual %0d", exp_r.screen_y, act.screen_y);
            error_count++;
         end
         if (act.depth_term !== exp_r.depth_term) begin
            $error("depth_term: expected %0d, actual %0d", exp_r.depth_term,
                   act.depth_term);
            error_count++;
         end
         if (act.shade_level !== exp_r.shade_level) begin
            $error("shade_level: expected %0d, actual %0d", exp_r.shade_level,
                   act.shade_level);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic calm = 1'b0;        // last part of the run: no idling
   logic hold_off = 1'b0;    // long receiver stall requested
   logic stim_done = 1'b0;
   int   stall_cycles = 0;
   int   rsp_idle = 0;
   int   quiet_cycles = 0;
   point_scoreboard sb = new();

   tprs_req_if req_ch();
   tprs_rsp_if rsp_ch();

   torus_point_rotate_shade i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      req_ch.valid = 1'b0;
      req_ch.tube_angle = '0;
      req_ch.sweep_angle = '0;
      req_ch.tilt_angle = '0;
      req_ch.spin_angle = '0;
      rsp_ch.ready = 1'b0;
   end

   // Send one request, holding valid until accepted
   task automatic send_point(logic [15:0] tube, logic [15:0] sweep,
                             logic [15:0] tilt, logic [15:0] spin);
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 14);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.tube_angle <= tube;
      req_ch.sweep_angle <= sweep;
      req_ch.tilt_angle <= tilt;
      req_ch.spin_angle <= spin;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   function automatic logic [15:0] pick_angle();
      logic [15:0] corner [8] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000,
                                  16'hFFFF, 16'h3FFF, 16'h0001, 16'h7FFF};
      return ($urandom_range(0, 7) == 0) ? corner[$urandom_range(0, 7)]
                                         : 16'($urandom);
   endfunction

   // Stimulus
   initial begin
      logic [15:0] quarter [4] = '{16'h0000, 16'h4000, 16'h8000, 16'hC000};
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Quadrant corners of every angle, all-ones and near-overshoot phases
      for (int i = 0; i < 16; i++)
         send_point(quarter[i % 4], quarter[(i / 4) % 4], quarter[(i / 2) % 4],
                    quarter[(i + 1) % 4]);
      send_point(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
      send_point(16'h3FFF, 16'h4001, 16'hBFFF, 16'hC001);
      send_point(16'h0001, 16'h7FFF, 16'h8001, 16'hFFFE);
      // Tube facing the viewer: largest denominator
      send_point(16'h0000, 16'h4000, 16'h4000, 16'h0000);
      send_point(16'hC000, 16'hC000, 16'h4000, 16'h5555);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM * 3 / 10) hold_off <= 1'b1;
         if (i == N_RANDOM * 8 / 10) calm <= 1'b1;
         send_point(pick_angle(), pick_angle(), pick_angle(), pick_angle());
      end
      req_ch.valid <= 1'b0;
      stim_done <= 1'b1;
   end

   // Receiver: random stall bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_off && stall_cycles < 300) begin
         stall_cycles <= stall_cycles + 1;
         rsp_ch.ready <= 1'b0;
         if (stall_cycles == 299) hold_off <= 1'b0;
      end else if (!calm && rsp_idle > 0) begin
         rsp_idle <= rsp_idle - 1;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_idle <= $urandom_range(0, 13);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Note requests and check responses at each edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.note_request(req_ch.tube_angle, req_ch.sweep_angle,
                            req_ch.tilt_angle, req_ch.spin_angle);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_response('{rsp_ch.screen_x, rsp_ch.screen_y,
                                rsp_ch.depth_term, rsp_ch.shade_level});
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Drain and report
   initial begin
      wait (stim_done);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      if (sb.error_count == 0 && sb.pending_q.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

`default_nettype wire
